// ===== hdl/orsa_pkg.sv =====
// Shared types and constants for the outlier-rejecting sample average.
`timescale 1ns / 1ps
`default_nettype none
package orsa_pkg;

  localparam int IN_W   = 12;
  localparam int OUT_W  = 12;
  localparam int KEPT_W = 8;

  localparam logic [1:0] ACT_CLEAR     = 2'd0;
  localparam logic [1:0] ACT_ADD       = 2'd1;
  localparam logic [1:0] ACT_CLEAR_ADD = 2'd2;
  localparam logic [1:0] ACT_UNUSED    = 2'd3;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_CLEAR,
    OP_ADD,
    OP_CLEAR_ADD
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [IN_W-1:0] x;
    logic [IN_W-1:0] y;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_VAR,
    ST_KEEP,
    ST_DIV
  } state_e;

endpackage
`default_nettype wire

// ===== hdl/outlier_rejecting_sample_average.sv =====
// Top level: sigma-clipped mean of batched touch samples.
// Input channel: in_valid_i / in_stall_o with action_i, sample_x_i, sample_y_i.
// Output channel: out_valid_o / out_stall_i; every request gives exactly one
// result, in order. Results of requests that do not finish a batch are zero.
// A request is decoded into a two-entry queue; the back end pops it, writes
// the sample store and loads the result register. Such a request's result is
// registered after the queue, and one per cycle is sustained while results
// are not stalled and no batch is being processed.
// The request that fills the batch starts two passes over the store (variance,
// then keep test) through the single read port, then a bit-serial divide of a
// SUMW-bit sum (SUMW is sample bits plus count bits, 20 at the defaults).
// Meanwhile the queue fills and in_stall_o rises.
// Reset empties the queue and the result register and zeroes the fill count;
// the store is not cleared. A stalled result holds, and the back end pops no
// further request until the result register is free.
`timescale 1ns / 1ps
`default_nettype none
module outlier_rejecting_sample_average #(
  parameter int BATCH_SIZE  = 128,
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    action_i,
  input  wire logic [orsa_pkg::IN_W-1:0]     sample_x_i,
  input  wire logic [orsa_pkg::IN_W-1:0]     sample_y_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               done_res_o,
  output logic [orsa_pkg::OUT_W-1:0]         avg_x_o,
  output logic [orsa_pkg::OUT_W-1:0]         avg_y_o,
  output logic [orsa_pkg::KEPT_W-1:0]        kept_count_o,
  output logic                               fell_back_o
);
  import orsa_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  orsa_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i, .sample_x_i, .sample_y_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  orsa_back #(.BATCH_SIZE(BATCH_SIZE), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .out_valid_o, .out_stall_i, .done_res_o, .avg_x_o, .avg_y_o,
    .kept_count_o, .fell_back_o
  );

endmodule
`default_nettype wire

// ===== hdl/orsa_front.sv =====
// Request decode and two-entry command queue.
`timescale 1ns / 1ps
`default_nettype none
module orsa_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [1:0]               action_i,
  input  wire logic [orsa_pkg::IN_W-1:0] sample_x_i,
  input  wire logic [orsa_pkg::IN_W-1:0] sample_y_i,
  output logic                          cmd_valid_o,
  output orsa_pkg::cmd_t                cmd_o,
  input  wire logic                     cmd_pop_i
);
  import orsa_pkg::*;

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  op_e        op;
  logic       push;

  always_comb begin
    unique case (action_i)
      ACT_CLEAR:     op = OP_CLEAR;
      ACT_ADD:       op = OP_ADD;
      ACT_CLEAR_ADD: op = OP_CLEAR_ADD;
      default:       op = OP_NOP;
    endcase
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{op: op, x: sample_x_i, y: sample_y_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
    end
  end

endmodule
`default_nettype wire

// ===== hdl/orsa_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module orsa_div #(
  parameter int NW = 20,
  parameter int DW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               done_o,
  output logic [NW-1:0]      quotient_o
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q, div_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW:0]   shifted, diff;
  logic          ge;

  assign shifted    = {rem_q, quo_q[NW-1]};
  assign ge         = shifted >= {1'b0, div_q};
  assign diff       = shifted - {1'b0, div_q};
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/orsa_back.sv =====
// Sample store, batch statistics passes and result register.
`timescale 1ns / 1ps
`default_nettype none
module orsa_back #(
  parameter int BATCH_SIZE  = 128,
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cmd_valid_i,
  input  wire orsa_pkg::cmd_t              cmd_i,
  output logic                             cmd_pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             done_res_o,
  output logic [orsa_pkg::OUT_W-1:0]       avg_x_o,
  output logic [orsa_pkg::OUT_W-1:0]       avg_y_o,
  output logic [orsa_pkg::KEPT_W-1:0]      kept_count_o,
  output logic                             fell_back_o
);
  import orsa_pkg::*;

  localparam int SW   = (SAMPLE_BITS < IN_W) ? SAMPLE_BITS : IN_W;
  localparam int NB   = $clog2(BATCH_SIZE + 1);
  localparam int AW   = $clog2(BATCH_SIZE);
  localparam int SUMW = SW + NB;
  localparam int SQW  = 2 * SUMW;
  localparam int ACCW = SQW + NB;
  localparam logic [NB-1:0] N_C    = NB'(BATCH_SIZE);
  localparam logic [AW-1:0] LAST_C = AW'(BATCH_SIZE - 1);

  state_e state_q, state_d;

  logic [2*SW-1:0] mem [BATCH_SIZE];

  logic [AW-1:0]   fill_q, fill_d, wr_addr;
  logic [SUMW-1:0] sx_q, sy_q, base_x, base_y;
  logic            is_add, is_clr, completes, slot_free;
  logic [SW-1:0]   xs, ys;

  logic [NB-1:0]   rd_cnt_q;
  logic            pass_end, rd_en, div_start;

  // stats pipeline
  logic            v1_q, v2_q, v3_q, v4_q;
  logic [SW-1:0]   x1_q, y1_q, x2_q, y2_q, x3_q, y3_q, x4_q, y4_q;
  logic [SUMW-1:0] nx, ny;
  logic [SUMW:0]   difx, dify, negx, negy;
  logic [SUMW-1:0] dx_q, dy_q;
  logic [SQW-1:0]  sqx, sqy, sqx_q, sqy_q;
  logic [ACCW-1:0] nsqx, nsqy;
  logic            keep_q;

  logic [ACCW-1:0] dx2_q, dy2_q;
  logic [SUMW-1:0] kx_q, ky_q;
  logic [NB-1:0]   kept_q;

  logic [SUMW-1:0] dvd_x, dvd_y, qx, qy;
  logic [NB-1:0]   dvs;
  logic            dx_done, dy_done;
  logic            fb_q;

  logic [SUMW+OUT_W-1:0] qx_ext, qy_ext;
  logic [NB+KEPT_W-1:0]  kept_ext;
  logic                  load_zero, load_res;

  logic                  out_valid_q, done_q, fbo_q;
  logic [OUT_W-1:0]      avgx_q, avgy_q;
  logic [KEPT_W-1:0]     kepto_q;

  // request decode
  assign slot_free = !out_valid_q || !out_stall_i;
  assign is_add    = (cmd_i.op == OP_ADD) || (cmd_i.op == OP_CLEAR_ADD);
  assign is_clr    = (cmd_i.op == OP_CLEAR) || (cmd_i.op == OP_CLEAR_ADD);
  assign wr_addr   = is_clr ? '0 : fill_q;
  assign completes = is_add && (wr_addr == LAST_C);
  assign xs        = cmd_i.x[SW-1:0];
  assign ys        = cmd_i.y[SW-1:0];
  assign base_x    = (wr_addr == '0) ? '0 : sx_q;
  assign base_y    = (wr_addr == '0) ? '0 : sy_q;

  always_comb begin
    fill_d = fill_q;
    if (cmd_pop_o) begin
      if (is_add) fill_d = completes ? '0 : wr_addr + 1'b1;
      else if (is_clr) fill_d = '0;
    end
  end

  assign pass_end = (rd_cnt_q == N_C) && !(v1_q || v2_q || v3_q || v4_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (cmd_pop_o && completes) state_d = ST_VAR;
      ST_VAR:  if (pass_end) state_d = ST_KEEP;
      ST_KEEP: if (pass_end) state_d = ST_DIV;
      ST_DIV:  if (dx_done && dy_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_pop_o = 1'b0;
    rd_en     = 1'b0;
    div_start = 1'b0;
    load_res  = 1'b0;
    unique case (state_q)
      ST_IDLE: cmd_pop_o = cmd_valid_i && slot_free;
      ST_VAR:  rd_en = (rd_cnt_q != N_C);
      ST_KEEP: begin
        rd_en     = (rd_cnt_q != N_C);
        div_start = pass_end;
      end
      ST_DIV:  load_res = dx_done && dy_done;
      default: ;
    endcase
  end
  assign load_zero = cmd_pop_o && !completes;

  // store
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && is_add) mem[wr_addr] <= {xs, ys};
    if (rd_en) {x1_q, y1_q} <= mem[rd_cnt_q[AW-1:0]];
  end

  // deviation, square, scaled compare
  assign nx   = SUMW'(N_C) * SUMW'(x1_q);
  assign ny   = SUMW'(N_C) * SUMW'(y1_q);
  assign difx = {1'b0, nx} - {1'b0, sx_q};
  assign dify = {1'b0, ny} - {1'b0, sy_q};
  assign negx = -difx;
  assign negy = -dify;
  assign sqx  = SQW'(dx_q) * SQW'(dx_q);
  assign sqy  = SQW'(dy_q) * SQW'(dy_q);
  assign nsqx = ACCW'(N_C) * ACCW'(sqx_q);
  assign nsqy = ACCW'(N_C) * ACCW'(sqy_q);

  always_ff @(posedge clk_i) begin
    dx_q   <= difx[SUMW] ? negx[SUMW-1:0] : difx[SUMW-1:0];
    dy_q   <= dify[SUMW] ? negy[SUMW-1:0] : dify[SUMW-1:0];
    x2_q   <= x1_q;
    y2_q   <= y1_q;
    sqx_q  <= sqx;
    sqy_q  <= sqy;
    x3_q   <= x2_q;
    y3_q   <= y2_q;
    keep_q <= (nsqx < dx2_q) && (nsqy < dy2_q);
    x4_q   <= x3_q;
    y4_q   <= y3_q;
  end

  assign dvd_x = (kept_q != '0) ? kx_q : sx_q;
  assign dvd_y = (kept_q != '0) ? ky_q : sy_q;
  assign dvs   = (kept_q != '0) ? kept_q : N_C;

  orsa_div #(.NW(SUMW), .DW(NB)) u_div_x (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(dvd_x), .divisor_i(dvs),
    .done_o(dx_done), .quotient_o(qx)
  );
  orsa_div #(.NW(SUMW), .DW(NB)) u_div_y (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(dvd_y), .divisor_i(dvs),
    .done_o(dy_done), .quotient_o(qy)
  );

  assign qx_ext   = {{OUT_W{1'b0}}, qx};
  assign qy_ext   = {{OUT_W{1'b0}}, qy};
  assign kept_ext = {{KEPT_W{1'b0}}, kept_q};

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && is_add) begin
      sx_q <= base_x + SUMW'(xs);
      sy_q <= base_y + SUMW'(ys);
    end
    if (cmd_pop_o && completes) begin
      dx2_q  <= '0;
      dy2_q  <= '0;
      kx_q   <= '0;
      ky_q   <= '0;
      kept_q <= '0;
    end else begin
      if (state_q == ST_VAR && v3_q) begin
        dx2_q <= dx2_q + ACCW'(sqx_q);
        dy2_q <= dy2_q + ACCW'(sqy_q);
      end
      if (state_q == ST_KEEP && v4_q && keep_q) begin
        kx_q   <= kx_q + SUMW'(x4_q);
        ky_q   <= ky_q + SUMW'(y4_q);
        kept_q <= kept_q + 1'b1;
      end
    end
    if (div_start) fb_q <= (kept_q == '0);
    if (load_zero) begin
      done_q  <= 1'b0;
      avgx_q  <= '0;
      avgy_q  <= '0;
      kepto_q <= '0;
      fbo_q   <= 1'b0;
    end else if (load_res) begin
      done_q  <= 1'b1;
      avgx_q  <= qx_ext[OUT_W-1:0];
      avgy_q  <= qy_ext[OUT_W-1:0];
      kepto_q <= (32'(kept_q) > 32'd255) ? {KEPT_W{1'b1}} : kept_ext[KEPT_W-1:0];
      fbo_q   <= fb_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      rd_cnt_q    <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      if (pass_end) rd_cnt_q <= '0;
      else if (rd_en) rd_cnt_q <= rd_cnt_q + 1'b1;
      v1_q <= rd_en;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      if (load_zero || load_res) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign done_res_o   = done_q;
  assign avg_x_o      = avgx_q;
  assign avg_y_o      = avgy_q;
  assign kept_count_o = kepto_q;
  assign fell_back_o  = fbo_q;

endmodule
`default_nettype wire

// ===== sim/orsa_checker.sv =====
// Checker: watches both channels, predicts the clipped mean and compares results.
`timescale 1ns / 1ps
module orsa_checker #(
  parameter int BATCH_SIZE = 128
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic                      in_stall_i,
  input  wire logic [1:0]                action_i,
  input  wire logic [orsa_pkg::IN_W-1:0] sample_x_i,
  input  wire logic [orsa_pkg::IN_W-1:0] sample_y_i,
  input  wire logic                      out_valid_i,
  input  wire logic                      out_stall_i,
  input  wire logic                      done_res_i,
  input  wire logic [orsa_pkg::OUT_W-1:0]  avg_x_i,
  input  wire logic [orsa_pkg::OUT_W-1:0]  avg_y_i,
  input  wire logic [orsa_pkg::KEPT_W-1:0] kept_count_i,
  input  wire logic                      fell_back_i,
  output int                             errors_o,
  output int                             pending_o,
  output int                             batches_o
);
  import orsa_pkg::*;

  typedef struct packed {
    logic              done;
    logic [OUT_W-1:0]  ax;
    logic [OUT_W-1:0]  ay;
    logic [KEPT_W-1:0] kept;
    logic              fb;
  } avg_res_t;

  logic [IN_W-1:0] buf_x [BATCH_SIZE];
  logic [IN_W-1:0] buf_y [BATCH_SIZE];
  int unsigned fill;
  avg_res_t expected_q[$];

  // keep test: N*d^2 < sum(d^2), exact in 64-bit integers
  function automatic avg_res_t clip_mean();
    avg_res_t r;
    longint sx, sy, dx2, dy2, kx, ky, a, b;
    int unsigned kept;
    sx = 0; sy = 0; dx2 = 0; dy2 = 0; kx = 0; ky = 0; kept = 0;
    for (int i = 0; i < BATCH_SIZE; i++) begin
      sx += buf_x[i];
      sy += buf_y[i];
    end
    for (int i = 0; i < BATCH_SIZE; i++) begin
      a = BATCH_SIZE * longint'(buf_x[i]) - sx;
      b = BATCH_SIZE * longint'(buf_y[i]) - sy;
      dx2 += a * a;
      dy2 += b * b;
    end
    for (int i = 0; i < BATCH_SIZE; i++) begin
      a = BATCH_SIZE * longint'(buf_x[i]) - sx;
      b = BATCH_SIZE * longint'(buf_y[i]) - sy;
      if (BATCH_SIZE * a * a < dx2 && BATCH_SIZE * b * b < dy2) begin
        kx += buf_x[i];
        ky += buf_y[i];
        kept++;
      end
    end
    r.done = 1'b1;
    if (kept > 0) begin
      r.ax = OUT_W'(kx / kept);
      r.ay = OUT_W'(ky / kept);
      r.fb = 1'b0;
    end else begin
      r.ax = OUT_W'(sx / BATCH_SIZE);
      r.ay = OUT_W'(sy / BATCH_SIZE);
      r.fb = 1'b1;
    end
    r.kept = (kept > 255) ? 8'd255 : KEPT_W'(kept);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    avg_res_t e, got;
    if (!rst_ni) begin
      fill = 0;
      expected_q.delete();
      errors_o <= 0;
      batches_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{done_res_i, avg_x_i, avg_y_i, kept_count_i, fell_back_i};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors_o <= errors_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (got !== e) begin
            $display("%0t: expected %p, got %p", $time, e, got);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        e = '0;
        if (action_i == ACT_CLEAR || action_i == ACT_CLEAR_ADD) fill = 0;
        if (action_i == ACT_ADD || action_i == ACT_CLEAR_ADD) begin
          if (fill >= BATCH_SIZE) fill = 0;
          buf_x[fill] = sample_x_i;
          buf_y[fill] = sample_y_i;
          fill++;
          if (fill >= BATCH_SIZE) begin
            e = clip_mean();
            fill = 0;
            batches_o <= batches_o + 1;
          end
        end
        expected_q.push_back(e);
      end
    end
  end

  assign pending_o = expected_q.size();
endmodule

// ===== sim/tb.sv =====
// Testbench top: drives requests with bursts and gaps, stalls results, gives the verdict.
`timescale 1ns / 1ps
module tb;
  import orsa_pkg::*;

  localparam int BATCH = 128;

  logic clk_i, rst_ni;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [1:0] action;
  logic [IN_W-1:0] sx, sy;
  logic done_res, fell_back;
  logic [OUT_W-1:0] ax, ay;
  logic [KEPT_W-1:0] kept;
  int errors, pending, batches;
  int requests;

  outlier_rejecting_sample_average #(.BATCH_SIZE(BATCH)) dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .action_i(action), .sample_x_i(sx), .sample_y_i(sy),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .done_res_o(done_res), .avg_x_o(ax), .avg_y_o(ay),
    .kept_count_o(kept), .fell_back_o(fell_back)
  );

  orsa_checker #(.BATCH_SIZE(BATCH)) chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .action_i(action), .sample_x_i(sx), .sample_y_i(sy),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .done_res_i(done_res), .avg_x_i(ax), .avg_y_i(ay),
    .kept_count_i(kept), .fell_back_i(fell_back),
    .errors_o(errors), .pending_o(pending), .batches_o(batches)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver stall pattern: quiet spells, then random stalls
  initial begin
    int phase;
    out_stall = 1'b0;
    phase = 0;
    forever begin
      @(posedge clk_i);
      phase = (phase + 1) % 600;
      out_stall <= (phase > 300) ? ($urandom_range(0, 3) == 0) : 1'b0;
    end
  end

  int burst_left;

  // send one request; gaps come between bursts, valid stays high inside a burst
  task automatic send_request(input logic [1:0] act, input logic [IN_W-1:0] x,
                              input logic [IN_W-1:0] y);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    action <= act;
    sx <= x;
    sy <= y;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    requests++;
  endtask

  task automatic random_sample(output logic [IN_W-1:0] x, output logic [IN_W-1:0] y,
                               input int cx, input int cy);
    if ($urandom_range(0, 9) == 0) begin
      x = IN_W'($urandom());
      y = IN_W'($urandom());
    end else begin
      x = IN_W'(cx + $urandom_range(0, 60) - 30);
      y = IN_W'(cy + $urandom_range(0, 60) - 30);
    end
  endtask

  initial begin
    logic [IN_W-1:0] x, y;
    int cx, cy, cycles;
    in_valid = 1'b0;
    action = ACT_CLEAR;
    sx = '0;
    sy = '0;
    burst_left = 0;
    requests = 0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: clear, unused code, clear-then-add, extremes
    send_request(ACT_CLEAR, 12'hFFF, 12'hFFF);
    send_request(ACT_UNUSED, 12'hABC, 12'h123);
    send_request(ACT_CLEAR_ADD, 12'h000, 12'hFFF);
    send_request(ACT_ADD, 12'hFFF, 12'h000);
    send_request(ACT_CLEAR, 12'h000, 12'h000);
    // degenerate batch: all equal, falls back
    for (int i = 0; i < BATCH; i++) send_request(ACT_ADD, 12'hFFF, 12'hFFF);
    // extreme two-valued batch: every deviation equals sigma, none kept
    for (int i = 0; i < BATCH; i++)
      send_request(ACT_ADD, (i % 2) ? 12'hFFF : 12'h000, (i % 2) ? 12'h000 : 12'hFFF);
    // random: mostly full batches of clustered touches with outliers
    while (requests < 450) begin
      cx = $urandom_range(0, 4095);
      cy = $urandom_range(0, 4095);
      if ($urandom_range(0, 7) == 0) begin
        random_sample(x, y, cx, cy);
        send_request(2'($urandom_range(0, 3)), x, y);
      end else begin
        random_sample(x, y, cx, cy);
        send_request(ACT_CLEAR_ADD, x, y);
        for (int i = 1; i < BATCH; i++) begin
          random_sample(x, y, cx, cy);
          if ($urandom_range(0, 199) == 0) send_request(ACT_UNUSED, x, y);
          send_request(ACT_ADD, x, y);
        end
      end
    end
    in_valid <= 1'b0;
    cycles = 0;
    while (pending != 0 && cycles < 20000) begin
      @(posedge clk_i);
      cycles++;
    end
    repeat (2 * BATCH + 60) @(posedge clk_i);
    $display("Sent %0d requests; %0d full batches checked, incl. fallback and extremes.",
             requests, batches);
    if (errors == 0 && pending == 0)
      $display("outlier_rejecting_sample_average: match");
    else
      $display("outlier_rejecting_sample_average: mismatch");
    $finish;
  end

  initial begin
    #4000000;
    $display("outlier_rejecting_sample_average: mismatch");
    $finish;
  end
endmodule
